FILE: design/sensor_dump_collector_assert.svh
// ----------------------------------------------------------------------------
// sensor_dump_collector assertion macros
// Clocked, reset-gated property forms shared by the checker.
// ----------------------------------------------------------------------------
`ifndef SENSOR_DUMP_COLLECTOR_ASSERT_SVH
`define SENSOR_DUMP_COLLECTOR_ASSERT_SVH

// same-cycle implication
`define SDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Types, codes and reset constants of the sensor dump collector.
// ----------------------------------------------------------------------------
package sdc_pkg;

	localparam int MODULES_DEF = 5;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [7:0] TIMEOUT_RST = 8'd6;
	localparam logic [7:0] POLL_RST    = 8'd133;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_POLL    = 2'd0,
		KIND_CHG     = 2'd1,
		KIND_QRY     = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	typedef enum logic {
		REG_TIMEOUT = 1'b0,
		REG_POLL    = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTE_CHK,
		ST_TICK_CHK,
		ST_CHG,
		ST_QRY,
		ST_RESTART,
		ST_POLL
	} st_t;

	typedef struct packed {
		logic  take_byte;
		logic  take_tick;
		logic  commit;
		logic  clear_round;
		logic  load;
		kind_t emit;
		logic  idx_inc;
		logic  idx_clr;
	} dp_cmd_t;

	typedef struct packed {
		logic complete;
		logic changed;
		logic timeout;
		logic idx_last;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: design/sensor_dump_collector.sv
// ----------------------------------------------------------------------------
// sensor_dump_collector
// Gathers polled sensor dumps into 16-bit words and reports changes,
// queries, timeouts and poll requests.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   item     | item_valid/stall     | command, rx_byte
//   result   | result_valid/stall   | kind, module_index, word_value, last
//   config   | APB psel/penable     | paddr, pwdata, prdata
//
// A query emits MODULES results; a completed round emits MODULES change
// results and a poll if changed, else a poll; a timeout a restart and a poll.
// The sequencer emits one result per cycle into a single output register
// unless result stall holds it; no new word is taken until all results of
// the current one are loaded. Reset clears the round, snapshot and registers.
// ----------------------------------------------------------------------------
module sensor_dump_collector
	import sdc_pkg::*;
#(
	parameter int MODULES = MODULES_DEF
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        command,
	input  logic [7:0]        rx_byte,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [1:0]        kind,
	output logic [2:0]        module_index,
	output logic [15:0]       word_value,
	output logic              last
);

	logic [7:0] timeout_ticks_q;
	logic [7:0] poll_code_q;
	reg_idx_t   reg_sel;
	dp_cmd_t    cmd;
	dp_sts_t    sts;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_RST;
			poll_code_q     <= POLL_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_TIMEOUT: timeout_ticks_q <= pwdata[7:0];
				REG_POLL:    poll_code_q     <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_TIMEOUT: prdata = {{(DATA_W-8){1'b0}}, timeout_ticks_q};
			REG_POLL:    prdata = {{(DATA_W-8){1'b0}}, poll_code_q};
			default:     prdata = '0;
		endcase
	end

	sdc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.command    (command),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	sdc_dp #(
		.MODULES (MODULES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.rx_byte       (rx_byte),
		.timeout_ticks (timeout_ticks_q),
		.poll_code     (poll_code_q),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.module_index  (module_index),
		.word_value    (word_value),
		.last          (last)
	);

endmodule

FILE: design/sdc_ctrl.sv
// ----------------------------------------------------------------------------
// sdc_ctrl
// Sequencer: accepts one word, checks round state, steps out the results.
// ----------------------------------------------------------------------------
module sdc_ctrl
	import sdc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic [1:0] command,
	output logic    item_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.emit   = KIND_POLL;
		item_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (cmd_t'(command))
						CMD_BYTE: begin
							cmd.take_byte = 1'b1;
							state_d       = ST_BYTE_CHK;
						end
						CMD_TICK: begin
							cmd.take_tick = 1'b1;
							state_d       = ST_TICK_CHK;
						end
						CMD_QUERY: state_d = ST_QRY;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_BYTE_CHK: begin
				if (sts.complete) begin
					cmd.clear_round = 1'b1;
					cmd.commit      = sts.changed;
					state_d         = sts.changed ? ST_CHG : ST_POLL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK_CHK: begin
				if (sts.timeout) begin
					cmd.clear_round = 1'b1;
					state_d         = ST_RESTART;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CHG, ST_QRY: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.emit = (state_q == ST_CHG) ? KIND_CHG : KIND_QRY;
					if (sts.idx_last) begin
						cmd.idx_clr = 1'b1;
						state_d     = (state_q == ST_CHG) ? ST_POLL : ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_RESTART: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.emit = KIND_RESTART;
					state_d  = ST_POLL;
				end
			end
			ST_POLL: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.emit = KIND_POLL;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: design/sdc_dp.sv
// ----------------------------------------------------------------------------
// sdc_dp
// Round gathering, snapshot store, idle tick count and result register.
// ----------------------------------------------------------------------------
module sdc_dp
	import sdc_pkg::*;
#(
	parameter int MODULES = MODULES_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  timeout_ticks,
	input  logic [7:0]  poll_code,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [2:0]  module_index,
	output logic [15:0] word_value,
	output logic        last
);

	localparam int IDXW = (MODULES > 1) ? $clog2(MODULES) : 1;
	localparam int BSW  = $clog2(2 * MODULES + 1);

	logic [15:0]     gather_q [MODULES];
	logic [15:0]     stored_q [MODULES];
	logic [BSW-1:0]  bytes_seen_q;
	logic [7:0]      ticks_idle_q;
	logic [IDXW-1:0] idx_q;
	logic [IDXW-1:0] slot;
	logic            changed;

	logic            res_valid_q;
	kind_t           kind_q;
	logic [2:0]      module_index_q;
	logic [15:0]     word_q;
	logic            last_q;

	assign slot = bytes_seen_q[IDXW:1];

	always_comb begin
		changed = 1'b0;
		for (int i = 0; i < MODULES; i++) begin
			if (gather_q[i] != stored_q[i]) changed = 1'b1;
		end
	end

	assign sts.complete = (bytes_seen_q == BSW'(2 * MODULES));
	assign sts.changed  = changed;
	assign sts.timeout  = (ticks_idle_q >= timeout_ticks);
	assign sts.idx_last = (idx_q == IDXW'(MODULES - 1));
	assign sts.out_free = !res_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MODULES; i++) begin
				gather_q[i] <= '0;
				stored_q[i] <= '0;
			end
			bytes_seen_q <= '0;
			ticks_idle_q <= '0;
			idx_q        <= '0;
		end else begin
			if (cmd.take_byte) begin
				for (int i = 0; i < MODULES; i++) begin
					if (slot == IDXW'(i)) begin
						if (bytes_seen_q[0]) begin
							gather_q[i][15:8] <= gather_q[i][15:8] | rx_byte;
						end else begin
							gather_q[i][7:0] <= gather_q[i][7:0] | rx_byte;
						end
					end
				end
				bytes_seen_q <= bytes_seen_q + 1'b1;
				ticks_idle_q <= '0;
			end
			if (cmd.take_tick && ticks_idle_q != 8'hFF) begin
				ticks_idle_q <= ticks_idle_q + 1'b1;
			end
			if (cmd.commit) begin
				for (int i = 0; i < MODULES; i++) stored_q[i] <= gather_q[i];
			end
			if (cmd.clear_round) begin
				for (int i = 0; i < MODULES; i++) gather_q[i] <= '0;
				bytes_seen_q <= '0;
				ticks_idle_q <= '0;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= cmd.emit;
			case (cmd.emit)
				KIND_CHG, KIND_QRY: begin
					module_index_q <= 3'(idx_q);
					word_q         <= stored_q[idx_q];
					last_q         <= (cmd.emit == KIND_QRY) && sts.idx_last;
				end
				KIND_POLL: begin
					module_index_q <= '0;
					word_q         <= {8'h00, poll_code};
					last_q         <= 1'b1;
				end
				default: begin
					module_index_q <= '0;
					word_q         <= '0;
					last_q         <= 1'b0;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign kind         = kind_q;
	assign module_index = module_index_q;
	assign word_value   = word_q;
	assign last         = last_q;

endmodule

FILE: design/sdc_checker.sv
// ----------------------------------------------------------------------------
// sdc_checker
// Port-level checks of the sensor dump collector, bound to the top level.
// ----------------------------------------------------------------------------
`include "sensor_dump_collector_assert.svh"

module sdc_checker
	import sdc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic [1:0]  command,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  kind,
	input logic [2:0]  module_index,
	input logic [15:0] word_value,
	input logic        last
);

	`SDC_ASSERT_NEXT(a_hold_result, result_valid && result_stall, result_valid && $stable(kind) && $stable(module_index) && $stable(word_value) && $stable(last), "stalled result changed")
	`SDC_ASSERT_NOW(a_poll_form, result_valid && kind == KIND_POLL, last && module_index == 3'd0 && word_value[15:8] == 8'h00, "malformed poll result")
	`SDC_ASSERT_NOW(a_restart_form, result_valid && kind == KIND_RESTART, !last && module_index == 3'd0 && word_value == 16'h0000, "malformed restart result")
	`SDC_ASSERT_NEXT(a_query_busy, item_valid && !item_stall && command == CMD_QUERY, item_stall, "query did not hold input")

endmodule

bind sensor_dump_collector sdc_checker u_sdc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.command      (command),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.kind         (kind),
	.module_index (module_index),
	.word_value   (word_value),
	.last         (last)
);

FILE: tb/sensor_dump_collector_tb.sv
// ----------------------------------------------------------------------------
// sensor_dump_collector_tb
// Self-checking bench for the sensor dump collector. A driver feeds link
// words (dump bytes, timer ticks, snapshot queries) from a queue, and a
// monitor folds every accepted word into a cycle-free copy of the collector
// to build the results due. Each result is matched in order against them.
// Phases cover the reset settings, a one-tick and a zero-tick timeout, the
// longest timeout, and random settings, with idle and stall gaps on both
// sides as well as stretches without any.
// ----------------------------------------------------------------------------
module sensor_dump_collector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdc_pkg::*;

	localparam int MODULES       = MODULES_DEF;
	localparam int ROUND_BYTES   = 2 * MODULES;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		cmd_t       cmd;
		logic [7:0] data;
	} link_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  module_idx;
		logic [15:0] value;
		logic        last;
	} report_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	logic [1:0]        command      = CMD_NONE;
	logic [7:0]        rx_byte      = 8'h00;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [1:0]        kind;
	logic [2:0]        module_index;
	logic [15:0]       word_value;
	logic              last;

	link_word_t words_to_send[$];
	report_t    reports_due[$];
	link_word_t next_word;
	report_t    seen_report;
	report_t    due_report;

	logic [15:0] round_words [MODULES]     = '{default: 16'h0000};
	logic [15:0] snapshot    [MODULES]     = '{default: 16'h0000};
	logic [7:0]  prev_round  [ROUND_BYTES] = '{default: 8'h00};
	logic [7:0]  extreme_round [ROUND_BYTES] =
		'{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};
	int          byte_count  = 0;
	int          idle_ticks  = 0;
	logic [7:0]  limit_ticks = TIMEOUT_RST;
	logic [7:0]  poll_byte   = POLL_RST;

	logic item_taken   = 1'b0;
	logic send_idle    = 1'b0;
	logic recv_idle    = 1'b0;
	int   gap_left     = 0;
	int   stall_left   = 0;
	int   words_queued = 0;
	int   words_taken  = 0;
	int   mismatches   = 0;

	sensor_dump_collector #(.MODULES(MODULES)) dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void clear_round();
		foreach (round_words[i])
			round_words[i] = 16'h0000;
		byte_count = 0;
		idle_ticks = 0;
	endfunction

	function automatic void expect_report(kind_t k, int idx, logic [15:0] v, logic l);
		report_t r;
		r.kind       = k;
		r.module_idx = 3'(idx);
		r.value      = v;
		r.last       = l;
		reports_due.push_back(r);
	endfunction

	function automatic void absorb_word(cmd_t c, logic [7:0] d);
		logic changed;
		int   slot;
		changed = 1'b0;
		case (c)
			CMD_BYTE: begin
				slot = byte_count / 2;
				if (slot < MODULES)
					round_words[slot] |= (byte_count % 2) ? {d, 8'h00} : {8'h00, d};
				byte_count++;
				idle_ticks = 0;
				if (byte_count >= ROUND_BYTES) begin
					foreach (round_words[i])
						if (round_words[i] != snapshot[i])
							changed = 1'b1;
					if (changed) begin
						foreach (snapshot[i]) begin
							snapshot[i] = round_words[i];
							expect_report(KIND_CHG, i, snapshot[i], 1'b0);
						end
					end
					expect_report(KIND_POLL, 0, {8'h00, poll_byte}, 1'b1);
					clear_round();
				end
			end
			CMD_TICK: begin
				if (idle_ticks < 255)
					idle_ticks++;
				if (idle_ticks >= limit_ticks) begin
					clear_round();
					expect_report(KIND_RESTART, 0, 16'h0000, 1'b0);
					expect_report(KIND_POLL, 0, {8'h00, poll_byte}, 1'b1);
				end
			end
			CMD_QUERY: begin
				foreach (snapshot[i])
					expect_report(KIND_QRY, i, snapshot[i], i == MODULES - 1);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ns mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// accept, predict and check
	always @(posedge clk) begin
		item_taken = arst_n && item_valid && !item_stall;
		if (item_taken) begin
			absorb_word(cmd_t'(command), rx_byte);
			words_taken++;
		end
		if (arst_n && result_valid && !result_stall) begin
			seen_report.kind       = kind_t'(kind);
			seen_report.module_idx = module_index;
			seen_report.value      = word_value;
			seen_report.last       = last;
			if (reports_due.size() == 0) begin
				report_mismatch($sformatf("result with none due: kind %0d module %0d value %h last %0d",
					kind, module_index, word_value, last));
			end else begin
				due_report = reports_due.pop_front();
				if (seen_report != due_report)
					report_mismatch($sformatf(
						"got kind %0d module %0d value %h last %0d, want %0d %0d %h %0d",
						seen_report.kind, seen_report.module_idx, seen_report.value,
						seen_report.last, due_report.kind, due_report.module_idx,
						due_report.value, due_report.last));
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (gap_left > 0) begin
				item_valid <= 1'b0;
				gap_left   <= gap_left - 1;
			end else if (words_to_send.size() > 0) begin
				next_word  = words_to_send.pop_front();
				command    <= next_word.cmd;
				rx_byte    <= next_word.data;
				item_valid <= 1'b1;
				gap_left   <= send_idle ? idle_len() : 0;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if (recv_idle && $urandom_range(0, 2) == 0) begin
			result_stall <= 1'b1;
			stall_left   <= idle_len();
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic send(cmd_t c, logic [7:0] d);
		link_word_t w;
		w.cmd  = c;
		w.data = d;
		words_to_send.push_back(w);
		words_queued++;
	endtask

	task automatic write_reg(reg_idx_t r, logic [7:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (r)
			REG_TIMEOUT: limit_ticks = v;
			REG_POLL:    poll_byte   = v;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// hold until every word is taken and every result is in
	task automatic settle_idle();
		do
			@(negedge clk);
		while (words_taken != words_queued || reports_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic add_random(int count);
		int done;
		int n;
		int r;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				if ($urandom_range(0, 9) >= 4)
					foreach (prev_round[i])
						prev_round[i] = pick_byte();
				foreach (prev_round[i]) begin
					send(CMD_BYTE, prev_round[i]);
					if ($urandom_range(0, 9) == 0) begin
						send(CMD_TICK, 8'($urandom));
						done++;
					end
				end
				done += ROUND_BYTES;
			end else if (r < 70) begin
				send(CMD_QUERY, 8'($urandom));
				done++;
			end else if (r < 85) begin
				n = $urandom_range(1, ROUND_BYTES - 1);
				repeat (n) send(CMD_BYTE, pick_byte());
				done += n;
				n = (limit_ticks == 0) ? 1 : limit_ticks;
				repeat (n) send(CMD_TICK, 8'($urandom));
				done += n;
			end else if (r < 95) begin
				n = $urandom_range(1, 3);
				repeat (n) send(CMD_TICK, 8'($urandom));
				done += n;
			end else begin
				send(CMD_NONE, 8'($urandom));
				done++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send(CMD_QUERY, 8'h00);
		repeat (ROUND_BYTES) send(CMD_BYTE, 8'h00);
		foreach (extreme_round[i])
			send(CMD_BYTE, extreme_round[i]);
		send(CMD_QUERY, 8'hFF);
		send(CMD_NONE, 8'hFF);
		settle_idle();

		write_reg(REG_TIMEOUT, 8'd1);
		write_reg(REG_POLL, 8'hFF);
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send(CMD_BYTE, 8'h3C);
		send(CMD_TICK, 8'h00);
		send(CMD_TICK, 8'hFF);
		add_random(40);
		settle_idle();

		write_reg(REG_TIMEOUT, 8'd0);
		write_reg(REG_POLL, 8'h00);
		recv_idle = 1'b0;
		send(CMD_TICK, 8'h00);
		send(CMD_BYTE, 8'hA5);
		send(CMD_TICK, 8'h00);
		add_random(20);
		settle_idle();

		write_reg(REG_TIMEOUT, 8'd255);
		write_reg(REG_POLL, 8'h5A);
		send_idle = 1'b0;
		recv_idle = 1'b1;
		repeat (255) send(CMD_TICK, 8'($urandom));
		send(CMD_QUERY, 8'h00);
		settle_idle();

		for (int p = 0; p < 4; p++) begin
			write_reg(REG_TIMEOUT, 8'($urandom_range(2, 12)));
			write_reg(REG_POLL, 8'($urandom));
			send_idle = (p != 0);
			recv_idle = (p != 0);
			add_random(15);
			settle_idle();
		end

		if (reports_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", reports_due.size()));
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/sdc_pkg.sv
design/sdc_ctrl.sv
design/sdc_dp.sv
design/sensor_dump_collector.sv
design/sdc_checker.sv
tb/sensor_dump_collector_tb.sv
